// ===== rtl/pmlr_pkg.sv =====
// Shared constants and types of the PCM mix and linear resampler.
`timescale 1ns / 1ps

package pmlr_pkg;

	// Sample and rate widths
	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 17;
	localparam int WHOLE_W  = 8;
	localparam int CFG_IDX_W = 2;

	// Outputs per input interval, and per flush
	localparam int MAX_UPSAMPLE = 12;
	localparam int K_W = $clog2(MAX_UPSAMPLE + 1);

	// Divider geometry: the interpolation dividend 2*|num|+den needs 36 bits,
	// position dividends and all divisors need 18.
	localparam int DIV_W = 36;
	localparam int DVS_W = 18;
	localparam int POS_W = 18;
	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam logic [CNT_W-1:0] ITER_WIDE   = CNT_W'(DIV_W);
	localparam logic [CNT_W-1:0] ITER_NARROW = CNT_W'(POS_W);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IN_RATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_STEREO  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_STEREO = 2'd3;

	// Register reset values
	localparam logic [RATE_W-1:0] IN_RATE_RST  = 17'd44100;
	localparam logic [RATE_W-1:0] OUT_RATE_RST = 17'd16000;
	localparam logic IN_STEREO_RST  = 1'b1;
	localparam logic OUT_STEREO_RST = 1'b0;

	localparam logic [WHOLE_W-1:0] WHOLE_MAX = 8'hFF;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    dividend;   // left aligned
		logic [DVS_W-1:0]    divisor;
		logic [CNT_W-1:0]    iters;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_W-1:0]    quotient;
		logic [DVS_W-1:0]    remainder;
	} div_rsp_t;

endpackage

// ===== rtl/pmlr_ifs.sv =====
// Channel interfaces: frame input, result output, configuration writes.
`timescale 1ns / 1ps

interface pmlr_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] right_sample;
	logic                                chunk_end;

	modport source (output valid, output left_sample, output right_sample,
		output chunk_end, input ready);
	modport sink (input valid, input left_sample, input right_sample,
		input chunk_end, output ready);
endinterface

interface pmlr_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] out_left;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] out_right;
	logic                                run_last;

	modport source (output valid, output out_left, output out_right,
		output run_last, input ready);
	modport sink (input valid, input out_left, input out_right,
		input run_last, output ready);
endinterface

interface pmlr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pmlr_pkg::CFG_IDX_W-1:0]     index;
	logic [pmlr_pkg::RATE_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pcm_mix_linear_resampler_unit.sv =====
// Top level of the PCM mix and linear interpolation resampler.
`timescale 1ns / 1ps

// Takes one PCM frame per item, mixes stereo input to mono with (L+R)>>>1,
// and emits the linearly interpolated outputs that fall between the previous
// frame and this one, rounded half away from zero; on the chunk's last frame
// the last sample is repeated for the remaining output positions (at most 12
// each way) and the chunk state clears. The frame port is ready only between
// items. All arithmetic runs through one serial divider and one 16x18
// multiplier under a sequencer, so the cost is set by the divider: each
// interpolated result takes an interpolation divide and a position advance,
// each flush result a position advance, and when an interval exceeds the
// 12-output cap its remaining positions are skipped by a skip divide and a
// position advance. A result waits in a pending register until the next one
// or the end of the item tells whether it is the frame's last, then moves to
// the output register; a full output register stalls the sequencer only when
// a further result must be pushed out.
module pcm_mix_linear_resampler_unit (
	input  logic              clk,
	input  logic              arst_n,
	pmlr_cfg_if.sink          cfg,
	pmlr_in_if.sink           frame,
	pmlr_out_if.source        result
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_MUL_A,
		S_MUL_B,
		S_ABS,
		S_DIV_GO,
		S_DIV_WAIT,
		S_EMIT,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		OP_INTERP,
		OP_SKIP,
		OP_ADV
	} div_op_t;

	// Configuration registers
	logic [pmlr_pkg::RATE_W-1:0] in_rate_q;
	logic [pmlr_pkg::RATE_W-1:0] out_rate_q;
	logic                        in_stereo_q;
	logic                        out_stereo_q;

	// Chunk state
	logic signed [pmlr_pkg::SAMPLE_W-1:0] prev_q;
	logic                                 have_q;
	logic [pmlr_pkg::WHOLE_W-1:0]         whole_q;
	logic [pmlr_pkg::RATE_W-1:0]          rem_q;

	// Item working registers
	state_t                               state_q;
	div_op_t                              div_op_q;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] cur_q;
	logic                                 last_q;
	logic                                 flush_q;   // in the flush phase that ends each item
	logic [pmlr_pkg::K_W-1:0]             k_q;
	logic signed [34:0]                   acc_q;
	logic                                 neg_q;
	logic [pmlr_pkg::DIV_W-1:0]           dvd_q;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] val_q;

	// Pending and output results
	logic                                 pend_v_q;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] pend_val_q;
	logic                                 out_valid_q;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] out_left_q;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] out_right_q;
	logic                                 out_last_q;

	pmlr_pkg::div_req_t div_req;
	pmlr_pkg::div_rsp_t div_rsp;

	// A zero rate behaves as one
	logic [pmlr_pkg::RATE_W-1:0] ir;
	logic [pmlr_pkg::RATE_W-1:0] den;
	assign ir  = (in_rate_q  == '0) ? pmlr_pkg::RATE_W'(1) : in_rate_q;
	assign den = (out_rate_q == '0) ? pmlr_pkg::RATE_W'(1) : out_rate_q;

	// Mono mix, floor of the average
	logic signed [pmlr_pkg::SAMPLE_W:0] mix_sum;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] mono;
	assign mix_sum = {frame.left_sample[pmlr_pkg::SAMPLE_W-1], frame.left_sample}
		+ {frame.right_sample[pmlr_pkg::SAMPLE_W-1], frame.right_sample};
	assign mono = in_stereo_q ? mix_sum[pmlr_pkg::SAMPLE_W:1] : frame.left_sample;

	// Shared multiplier: prev*(den-rem), then cur*rem
	logic signed [pmlr_pkg::RATE_W:0]     den_minus_rem;
	logic signed [pmlr_pkg::SAMPLE_W-1:0] mul_x;
	logic signed [pmlr_pkg::RATE_W:0]     mul_y;
	logic signed [33:0]                   prod;
	assign den_minus_rem = $signed({1'b0, den}) - $signed({1'b0, rem_q});
	assign mul_x = (state_q == S_MUL_A) ? prev_q : cur_q;
	assign mul_y = (state_q == S_MUL_A) ? den_minus_rem : $signed({1'b0, rem_q});
	assign prod  = mul_x * mul_y;

	// Dividend of the rounded division: 2*|num| + den
	logic [34:0]               mag;
	logic [pmlr_pkg::DIV_W-1:0] interp_dvd;
	assign mag = acc_q[34] ? 35'(-acc_q) : 35'(acc_q);
	assign interp_dvd = {1'b0, mag[33:0], 1'b0} + pmlr_pkg::DIV_W'(den);

	// Position arithmetic
	localparam int PAD_W = pmlr_pkg::DIV_W - pmlr_pkg::POS_W;
	logic [pmlr_pkg::POS_W-1:0] step_t;    // rem + in_rate
	logic [pmlr_pkg::POS_W-1:0] gap_t;     // den - rem + in_rate - 1
	logic [pmlr_pkg::POS_W-1:0] skip_t;    // den + in_rate - 1 - (gap_t mod in_rate)
	assign step_t = {1'b0, rem_q} + {1'b0, ir};
	assign gap_t  = {1'b0, den} - {1'b0, rem_q} + {1'b0, ir} - pmlr_pkg::POS_W'(1);
	assign skip_t = {1'b0, den} + {1'b0, ir} - pmlr_pkg::POS_W'(1)
		- {1'b0, div_rsp.remainder[pmlr_pkg::RATE_W-1:0]};

	// Whole offset plus quotient, saturating
	logic [pmlr_pkg::WHOLE_W:0]   whole_sum;
	logic [pmlr_pkg::WHOLE_W-1:0] whole_next;
	assign whole_sum  = {1'b0, whole_q} + {1'b0, div_rsp.quotient[pmlr_pkg::WHOLE_W-1:0]};
	assign whole_next = ((|div_rsp.quotient[pmlr_pkg::POS_W-1:pmlr_pkg::WHOLE_W])
		|| whole_sum[pmlr_pkg::WHOLE_W]) ? pmlr_pkg::WHOLE_MAX
		: whole_sum[pmlr_pkg::WHOLE_W-1:0];

	// Interpolated value with sign restored
	logic [pmlr_pkg::SAMPLE_W-1:0] qlow;
	assign qlow = div_rsp.quotient[pmlr_pkg::SAMPLE_W-1:0];

	logic out_free;
	assign out_free = !out_valid_q || result.ready;

	// The pending result moves to the output register this cycle
	logic out_load;
	assign out_load = pend_v_q && out_free && (state_q == S_EMIT || state_q == S_FIN);

	always_comb begin
		div_req.start    = (state_q == S_DIV_GO);
		div_req.dividend = dvd_q;
		unique case (div_op_q)
			OP_INTERP: begin
				div_req.divisor = {den, 1'b0};
				div_req.iters   = pmlr_pkg::ITER_WIDE;
			end
			OP_SKIP: begin
				div_req.divisor = {1'b0, ir};
				div_req.iters   = pmlr_pkg::ITER_NARROW;
			end
			default: begin
				div_req.divisor = {1'b0, den};
				div_req.iters   = pmlr_pkg::ITER_NARROW;
			end
		endcase
	end

	pmlr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q    <= pmlr_pkg::IN_RATE_RST;
			out_rate_q   <= pmlr_pkg::OUT_RATE_RST;
			in_stereo_q  <= pmlr_pkg::IN_STEREO_RST;
			out_stereo_q <= pmlr_pkg::OUT_STEREO_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pmlr_pkg::REG_IN_RATE:    in_rate_q    <= cfg.data;
				pmlr_pkg::REG_OUT_RATE:   out_rate_q   <= cfg.data;
				pmlr_pkg::REG_IN_STEREO:  in_stereo_q  <= cfg.data[0];
				pmlr_pkg::REG_OUT_STEREO: out_stereo_q <= cfg.data[0];
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_op_q    <= OP_ADV;
			prev_q      <= '0;
			have_q      <= 1'b0;
			whole_q     <= '0;
			rem_q       <= '0;
			cur_q       <= '0;
			last_q      <= 1'b0;
			flush_q     <= 1'b0;
			k_q         <= '0;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			dvd_q       <= '0;
			val_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_val_q  <= '0;
			out_valid_q <= 1'b0;
			out_left_q  <= '0;
			out_right_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (frame.valid) begin
						cur_q   <= mono;
						last_q  <= frame.chunk_end;
						flush_q <= 1'b0;
						k_q     <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!flush_q) begin
						if (have_q && whole_q == '0
							&& k_q < pmlr_pkg::K_W'(pmlr_pkg::MAX_UPSAMPLE)) begin
							state_q <= S_MUL_A;
						end else if (have_q && whole_q == '0) begin
							// cap reached: jump past the rest of this interval
							dvd_q    <= {gap_t, {PAD_W{1'b0}}};
							div_op_q <= OP_SKIP;
							state_q  <= S_DIV_GO;
						end else begin
							if (have_q) begin
								whole_q <= whole_q - 1'b1;
							end
							prev_q  <= cur_q;
							have_q  <= 1'b1;
							flush_q <= 1'b1;
							k_q     <= '0;
						end
					end else if (last_q && whole_q == '0
						&& k_q < pmlr_pkg::K_W'(pmlr_pkg::MAX_UPSAMPLE)) begin
						val_q   <= prev_q;
						state_q <= S_EMIT;
					end else begin
						if (last_q) begin
							prev_q  <= '0;
							have_q  <= 1'b0;
							whole_q <= '0;
							rem_q   <= '0;
						end
						state_q <= S_FIN;
					end
				end
				S_MUL_A: begin
					acc_q   <= {prod[33], prod};
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					acc_q   <= acc_q + {prod[33], prod};
					state_q <= S_ABS;
				end
				S_ABS: begin
					neg_q    <= acc_q[34];
					dvd_q    <= interp_dvd;
					div_op_q <= OP_INTERP;
					state_q  <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						unique case (div_op_q)
							OP_INTERP: begin
								val_q   <= neg_q ? $signed(-qlow) : $signed(qlow);
								state_q <= S_EMIT;
							end
							OP_SKIP: begin
								dvd_q    <= {skip_t, {PAD_W{1'b0}}};
								div_op_q <= OP_ADV;
								state_q  <= S_DIV_GO;
							end
							default: begin
								whole_q <= whole_next;
								rem_q   <= div_rsp.remainder[pmlr_pkg::RATE_W-1:0];
								state_q <= S_CHK;
							end
						endcase
					end
				end
				S_EMIT: begin
					// a new result proves the pending one was not the frame's last
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_left_q  <= pend_val_q;
							out_right_q <= out_stereo_q ? pend_val_q : '0;
							out_last_q  <= 1'b0;
						end
						pend_v_q   <= 1'b1;
						pend_val_q <= val_q;
						k_q        <= k_q + 1'b1;
						dvd_q      <= {step_t, {PAD_W{1'b0}}};
						div_op_q   <= OP_ADV;
						state_q    <= S_DIV_GO;
					end
				end
				S_FIN: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_left_q  <= pend_val_q;
						out_right_q <= out_stereo_q ? pend_val_q : '0;
						out_last_q  <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign frame.ready     = (state_q == S_IDLE);
	assign result.valid    = out_valid_q;
	assign result.out_left = out_left_q;
	assign result.out_right = out_right_q;
	assign result.run_last = out_last_q;

endmodule

// ===== rtl/pmlr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pmlr_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pmlr_pkg::div_req_t   req,
	output pmlr_pkg::div_rsp_t   rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [pmlr_pkg::CNT_W-1:0]   cnt_q;
	logic [pmlr_pkg::DIV_W-1:0]   dvd_q;
	logic [pmlr_pkg::DIV_W-1:0]   quo_q;
	logic [pmlr_pkg::DVS_W-1:0]   rem_q;
	logic [pmlr_pkg::DVS_W-1:0]   dvs_q;

	logic [pmlr_pkg::DVS_W:0]     trial;
	logic [pmlr_pkg::DVS_W:0]     diff;
	logic                         fits;

	assign trial = {rem_q, dvd_q[pmlr_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			// pulse on the last quotient bit
			done_q <= !req.start && busy_q && (cnt_q == pmlr_pkg::CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				quo_q  <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[pmlr_pkg::DIV_W-2:0], 1'b0};
				quo_q <= {quo_q[pmlr_pkg::DIV_W-2:0], fits};
				rem_q <= fits ? diff[pmlr_pkg::DVS_W-1:0] : trial[pmlr_pkg::DVS_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pmlr_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
